FILE: src/lwf_pkg.sv
// ============================================================================
// lwf_pkg: shared types and constants of the line/wall follow controller
// Field layout of the stream words, fixed point constants, mode codes,
// register indexes and the navigation bundle passed between modules.
// ============================================================================
`default_nettype none

package lwf_pkg;

  // Line sensors
  localparam int IR_SENSORS = 5;
  localparam int IR_W       = 12;
  localparam int ERR_W      = 13;  // weighted error, -3000..3000
  localparam int DIFF_W     = ERR_W + 1;

  localparam logic signed [ERR_W-1:0] IR_WEIGHT [IR_SENSORS] = '{
    -13'sd2000, -13'sd1000, 13'sd0, 13'sd1000, 13'sd2000
  };

  // Field widths
  localparam int DIST_W  = 16;  // Q4.12
  localparam int POS_W   = 32;  // Q16.16, wrapping
  localparam int SPEED_W = 16;  // Q8.8
  localparam int GAIN_W  = 16;  // Q8.8
  localparam int LIMIT_W = 31;

  // Input word layout, lowest field first
  localparam int OFS_FRONT  = IR_SENSORS * IR_W;
  localparam int OFS_RIGHT  = OFS_FRONT + DIST_W;
  localparam int OFS_LPOS   = OFS_RIGHT + DIST_W;
  localparam int OFS_RPOS   = OFS_LPOS + POS_W;
  localparam int IN_USED_W  = OFS_RPOS + POS_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_TDATA_W = 2 * SPEED_W;
  localparam int MODE_W      = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_IR_THRESHOLD = 3'd3,
    CFG_FRONT_LIMIT  = 3'd4,
    CFG_WALL_TARGET  = 3'd5,
    CFG_TURN_LIMIT   = 3'd6
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 16'd230;
  localparam logic [IR_W-1:0]    RST_IR_THRESHOLD = 12'd512;
  localparam logic [DIST_W-1:0]  RST_FRONT_LIMIT  = 16'd5325;
  localparam logic [DIST_W-1:0]  RST_WALL_TARGET  = 16'd4915;
  localparam logic [LIMIT_W-1:0] RST_TURN_LIMIT   = 31'd335394;

  // Output mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_LINE = 2'd0,
    MODE_WALL = 2'd1,
    MODE_TURN = 2'd2
  } mode_e;

  // Speeds, Q8.8
  localparam logic signed [SPEED_W-1:0] SPEED_LINE_MAX = 16'sd2560;
  localparam logic signed [SPEED_W-1:0] SPEED_STRAIGHT = 16'sd1856;
  localparam logic signed [SPEED_W-1:0] SPEED_TURN     = 16'sd1280;

  // PID datapath widths
  localparam int P_W     = GAIN_W + 1 + ERR_W;   // prop * error
  localparam int D_W     = GAIN_W + 1 + DIFF_W;  // deriv * error delta
  localparam int INTEG_W = 32;
  localparam int SUM_W   = INTEG_W + 1;

  // Divide by 1000: magnitudes at or above the saturation point all clamp
  // the wheel speeds the same way, the rest fit MAG_W bits.
  localparam int                 MAG_W        = 22;
  localparam int                 CORR_W       = 12;
  localparam int                 RECIP_W      = 23;
  localparam int                 DIV_SHIFT    = 32;
  localparam logic [INTEG_W-1:0] DIV_SAT_MAG  = 32'd2561000;
  localparam logic [RECIP_W-1:0] DIV_RECIP    = 23'd4294968;  // ceil(2^32/1000)
  localparam logic [CORR_W-1:0]  CORR_SAT     = 12'd2561;

  // Pipeline: input register, products, sum, magnitude, quotient
  localparam int PIPE_DEPTH = 5;

  typedef struct packed {
    logic signed [SPEED_W-1:0] ls;
    logic signed [SPEED_W-1:0] rs;
    mode_e                     mode;
    logic                      use_pid;   // speeds come from the PID path
    logic                      pid_hold;  // a turn runs, keep PID state
  } nav_t;

endpackage

`default_nettype wire

FILE: src/lwf_nav.sv
// ============================================================================
// lwf_nav: wall following and turn sequencing
// Holds the wall/turn state, decides the mode of a tick and the speeds of
// the wall and turn paths; state advances when the tick is committed.
// ============================================================================
`default_nettype none

module lwf_nav
  import lwf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               commit_i,
  input  wire logic               line_all_i,
  input  wire logic [DIST_W-1:0]  front_i,
  input  wire logic [DIST_W-1:0]  right_i,
  input  wire logic [POS_W-1:0]   lpos_i,
  input  wire logic [POS_W-1:0]   rpos_i,
  input  wire logic [DIST_W-1:0]  front_limit_i,
  input  wire logic [DIST_W-1:0]  wall_target_i,
  input  wire logic [LIMIT_W-1:0] turn_limit_i,
  output nav_t                    nav_o
);

  logic              wall_seen_q, wall_seen_d;
  logic              turning_q, turning_d;
  logic [POS_W-1:0]  start_l_q, start_l_d;
  logic [POS_W-1:0]  start_r_q, start_r_d;

  logic [POS_W-1:0]          dl_c, dr_c;
  logic                      run_on_c, clear_c, limit_nz_c;
  logic signed [DIST_W:0]    e_c;
  logic signed [20:0]        e15_c, biased_c;
  logic signed [SPEED_W-1:0] steer_c;

  // Wrapping deltas read as signed; a negative delta keeps the turn going
  assign dl_c       = lpos_i - start_l_q;
  assign dr_c       = rpos_i - start_r_q;
  assign run_on_c   = (dl_c[POS_W-1] || (dl_c[LIMIT_W-1:0] < turn_limit_i)) &&
                      (dr_c[POS_W-1] || (dr_c[LIMIT_W-1:0] < turn_limit_i));
  assign limit_nz_c = (turn_limit_i != '0);
  assign clear_c    = (front_i < front_limit_i);

  // steer = 15*e/64, truncated toward zero
  assign e_c      = $signed({1'b0, right_i}) - $signed({1'b0, wall_target_i});
  assign e15_c    = (21'(e_c) <<< 4) - 21'(e_c);
  assign biased_c = e15_c + (e15_c[20] ? 21'sd63 : 21'sd0);
  assign steer_c  = 16'(biased_c >>> 6);

  always_comb begin
    wall_seen_d    = wall_seen_q;
    turning_d      = turning_q;
    start_l_d      = start_l_q;
    start_r_d      = start_r_q;
    nav_o.ls       = '0;
    nav_o.rs       = '0;
    nav_o.mode     = MODE_LINE;
    nav_o.use_pid  = 1'b0;
    nav_o.pid_hold = turning_q;
    if (turning_q) begin
      nav_o.mode = MODE_TURN;
      turning_d  = run_on_c;
      if (run_on_c) begin
        nav_o.ls = SPEED_TURN;
        nav_o.rs = -SPEED_TURN;
      end
    end else if (line_all_i) begin
      nav_o.mode = MODE_WALL;
      if (clear_c && !wall_seen_q) begin
        nav_o.ls = SPEED_STRAIGHT;
        nav_o.rs = SPEED_STRAIGHT;
      end else if (clear_c) begin
        nav_o.ls = SPEED_STRAIGHT + steer_c;
        nav_o.rs = SPEED_STRAIGHT - steer_c;
      end else begin
        // capture positions; deltas are zero on this tick
        nav_o.mode  = MODE_TURN;
        wall_seen_d = 1'b1;
        start_l_d   = lpos_i;
        start_r_d   = rpos_i;
        turning_d   = limit_nz_c;
        if (limit_nz_c) begin
          nav_o.ls = SPEED_TURN;
          nav_o.rs = -SPEED_TURN;
        end
      end
    end else begin
      nav_o.use_pid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_seen_q <= 1'b0;
      turning_q   <= 1'b0;
      start_l_q   <= '0;
      start_r_q   <= '0;
    end else if (commit_i) begin
      wall_seen_q <= wall_seen_d;
      turning_q   <= turning_d;
      start_l_q   <= start_l_d;
      start_r_q   <= start_r_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/lwf_div1000.sv
// ============================================================================
// lwf_div1000: two stage signed divide by 1000 of the PID sum
// Stage a takes the magnitude and flags saturation, stage b multiplies by
// the reciprocal. The quotient magnitude is clamped to one past full speed.
// ============================================================================
`default_nettype none

module lwf_div1000
  import lwf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_a_i,
  input  wire logic                    en_b_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  output logic         [CORR_W-1:0]    q_o,
  output logic                         neg_o
);

  logic [SUM_W-1:0]           abs_c;
  logic [MAG_W-1:0]           mag_a_q;
  logic                       sat_a_q, neg_a_q;
  logic [MAG_W+RECIP_W-1:0]   prod_c;
  logic [CORR_W-1:0]          q_q;
  logic                       neg_b_q;

  assign abs_c  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign prod_c = (MAG_W+RECIP_W)'(mag_a_q) * (MAG_W+RECIP_W)'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      neg_a_q <= sum_i[SUM_W-1];
      sat_a_q <= (abs_c[INTEG_W-1:0] >= DIV_SAT_MAG);
      mag_a_q <= abs_c[MAG_W-1:0];
    end
    if (en_b_i) begin
      neg_b_q <= neg_a_q;
      q_q     <= sat_a_q ? CORR_SAT : prod_c[DIV_SHIFT +: CORR_W];
    end
  end

  assign q_o   = q_q;
  assign neg_o = neg_b_q;

endmodule

`default_nettype wire

FILE: src/line_wall_follow_controller_core.sv
// ============================================================================
// line_wall_follow_controller_core: PID line follower with wall override
// One sensor snapshot in, one pair of wheel speed commands and a mode out.
// ============================================================================
// Usage:
//   s_axis carries one snapshot per control tick (five IR samples, front and
//   right distances, both wheel positions). m_axis returns one word per
//   snapshot with the left/right speeds in Q8.8 and the mode in tuser.
//   cfg writes one register per handshake; cfg_ready_o is always high.
//   Write registers only while no snapshot is in flight.
// Throughput:
//   One word per cycle is sustained while m_axis_tready_i is high: the five
//   register stages (input, PID products, PID sum, magnitude, reciprocal
//   multiply) and the output register each hold one tick, and the PID and
//   wall/turn state close their loops within the first stage.
// Stalls:
//   When m_axis_tready_i is low the output word holds; empty stages still
//   fill, so up to five more snapshots are taken before s_axis_tready_o drops.
// Reset:
//   rst_ni clears all valid bits, the PID and wall/turn state, and loads the
//   register defaults. No clearing pass is needed.
// ============================================================================
`default_nettype none

module line_wall_follow_controller_core
  import lwf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // snapshot: ir_far_left, ir_left, ir_center, ir_right, ir_far_right,
  //           front_dist, right_dist, left_wheel_pos, right_wheel_pos, pad
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result: left_speed, right_speed
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // result kind: mode
  output logic [MODE_W-1:0]           m_axis_tuser_o,
  // register writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  prop_q, integ_q, deriv_q;
  logic [IR_W-1:0]    thr_q;
  logic [DIST_W-1:0]  front_limit_q, wall_target_q;
  logic [LIMIT_W-1:0] turn_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q        <= RST_PROP_GAIN;
      integ_q       <= RST_INTEG_GAIN;
      deriv_q       <= RST_DERIV_GAIN;
      thr_q         <= RST_IR_THRESHOLD;
      front_limit_q <= RST_FRONT_LIMIT;
      wall_target_q <= RST_WALL_TARGET;
      turn_limit_q  <= RST_TURN_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROP_GAIN:    prop_q        <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:   integ_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:   deriv_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_IR_THRESHOLD: thr_q         <= cfg_data_i[IR_W-1:0];
        CFG_FRONT_LIMIT:  front_limit_q <= cfg_data_i[DIST_W-1:0];
        CFG_WALL_TARGET:  wall_target_q <= cfg_data_i[DIST_W-1:0];
        CFG_TURN_LIMIT:   turn_limit_q  <= cfg_data_i;
        default: ;  // unknown index: drop the word
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // moves, so bubbles collapse behind a stalled output.
  // --------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] v_q;
  logic [PIPE_DEPTH:0]   en_c;
  logic                  out_valid_q;
  logic                  commit_c;

  always_comb begin
    en_c[PIPE_DEPTH] = !out_valid_q || m_axis_tready_i;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      en_c[k] = !v_q[k] || en_c[k+1];
    end
  end

  assign s_axis_tready_o = en_c[0];
  assign commit_c        = v_q[0] && en_c[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_c[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en_c[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (en_c[PIPE_DEPTH]) begin
        out_valid_q <= v_q[PIPE_DEPTH-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register, line error, PID products, wall/turn decision
  // --------------------------------------------------------------------------
  logic [IN_USED_W-1:0] in_q;

  always_ff @(posedge clk_i) begin
    if (en_c[0] && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i[IN_USED_W-1:0];
    end
  end

  logic [IR_W-1:0]          ir_c [IR_SENSORS];
  logic signed [ERR_W-1:0]  err_c;
  logic                     line_all_c;

  always_comb begin
    err_c      = '0;
    line_all_c = 1'b1;
    for (int k = 0; k < IR_SENSORS; k++) begin
      ir_c[k] = in_q[k*IR_W +: IR_W];
      if (ir_c[k] >= thr_q) begin
        err_c = err_c + IR_WEIGHT[k];
      end else begin
        line_all_c = 1'b0;
      end
    end
  end

  // PID state: written back only on ticks that are not inside a turn
  logic signed [ERR_W-1:0]   last_err_q;
  logic signed [INTEG_W-1:0] integ_sum_q;

  logic signed [GAIN_W:0]    prop_s, integ_s, deriv_s;
  logic signed [DIFF_W-1:0]  diff_c;
  logic signed [P_W-1:0]     p_c, ip_c;
  logic signed [D_W-1:0]     d_c;
  logic signed [INTEG_W:0]   i_wide_c;
  logic signed [INTEG_W-1:0] i_c;

  assign prop_s  = $signed({1'b0, prop_q});
  assign integ_s = $signed({1'b0, integ_q});
  assign deriv_s = $signed({1'b0, deriv_q});
  assign diff_c  = DIFF_W'(err_c) - DIFF_W'(last_err_q);
  assign p_c     = P_W'(prop_s) * P_W'(err_c);
  assign ip_c    = P_W'(integ_s) * P_W'(err_c);
  assign d_c     = D_W'(deriv_s) * D_W'(diff_c);

  // saturate the running integral to 32 bits
  assign i_wide_c = (INTEG_W+1)'(integ_sum_q) + (INTEG_W+1)'(ip_c);
  always_comb begin
    if (i_wide_c[INTEG_W] != i_wide_c[INTEG_W-1]) begin
      i_c = i_wide_c[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                              : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      i_c = i_wide_c[INTEG_W-1:0];
    end
  end

  nav_t nav_c;

  lwf_nav u_nav (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (commit_c),
    .line_all_i    (line_all_c),
    .front_i       (in_q[OFS_FRONT +: DIST_W]),
    .right_i       (in_q[OFS_RIGHT +: DIST_W]),
    .lpos_i        (in_q[OFS_LPOS +: POS_W]),
    .rpos_i        (in_q[OFS_RPOS +: POS_W]),
    .front_limit_i (front_limit_q),
    .wall_target_i (wall_target_q),
    .turn_limit_i  (turn_limit_q),
    .nav_o         (nav_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      integ_sum_q <= '0;
    end else if (commit_c && !nav_c.pid_hold) begin
      last_err_q  <= err_c;
      integ_sum_q <= i_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..5: PID sum, divide by 1000; the decision rides along
  // --------------------------------------------------------------------------
  nav_t                      nav_q [PIPE_DEPTH-1];
  logic signed [P_W-1:0]     p_q;
  logic signed [INTEG_W-1:0] i_q;
  logic signed [D_W-1:0]     d_q;
  logic signed [SUM_W-1:0]   sum_q;

  always_ff @(posedge clk_i) begin
    if (commit_c) begin
      nav_q[0] <= nav_c;
      p_q      <= p_c;
      i_q      <= i_c;
      d_q      <= d_c;
    end
    if (en_c[2] && v_q[1]) begin
      sum_q <= SUM_W'(p_q) + SUM_W'(i_q) + SUM_W'(d_q);
    end
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      if (en_c[k+1] && v_q[k]) begin
        nav_q[k] <= nav_q[k-1];
      end
    end
  end

  logic [CORR_W-1:0] q_c;
  logic              neg_c;

  lwf_div1000 u_div (
    .clk_i  (clk_i),
    .en_a_i (en_c[3] && v_q[2]),
    .en_b_i (en_c[4] && v_q[3]),
    .sum_i  (sum_q),
    .q_o    (q_c),
    .neg_o  (neg_c)
  );

  // --------------------------------------------------------------------------
  // Output register: on PID ticks apply the correction, clamp to 0..full speed
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] slow_c, ls_c, rs_c;
  logic signed [SPEED_W-1:0] ls_q, rs_q;
  mode_e                     mode_q;
  nav_t                      nav_last;

  assign nav_last = nav_q[PIPE_DEPTH-2];
  assign slow_c   = (SPEED_W'(q_c) >= SPEED_LINE_MAX) ? '0
                                                      : SPEED_LINE_MAX - SPEED_W'(q_c);

  always_comb begin
    ls_c = nav_last.ls;
    rs_c = nav_last.rs;
    if (nav_last.use_pid) begin
      ls_c = neg_c ? slow_c : SPEED_LINE_MAX;
      rs_c = neg_c ? SPEED_LINE_MAX : slow_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c[PIPE_DEPTH] && v_q[PIPE_DEPTH-1]) begin
      ls_q   <= ls_c;
      rs_q   <= rs_c;
      mode_q <= nav_last.mode;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {rs_q, ls_q};
  assign m_axis_tuser_o  = mode_q;

endmodule

`default_nettype wire

FILE: src/lwf_checker.sv
// ============================================================================
// lwf_checker: port level checks of the line/wall follow controller
// Output stall behavior and the speed patterns each mode may show.
// ============================================================================
`default_nettype none

module lwf_checker
  import lwf_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [MODE_W-1:0]      m_axis_tuser_o
);

  logic [SPEED_W-1:0] ls_w, rs_w;
  assign ls_w = m_axis_tdata_o[SPEED_W-1:0];
  assign rs_w = m_axis_tdata_o[OUT_TDATA_W-1:SPEED_W];

  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_stall_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // a turn either spins at the turn speed or stops
  a_turn_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == MODE_TURN) |->
      ((ls_w == SPEED_TURN) && (rs_w == 16'(-SPEED_TURN))) ||
      ((ls_w == '0) && (rs_w == '0)))
    else $error("turn word with unexpected speeds");

  // line following slows at most one wheel, never below zero
  a_line_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == MODE_LINE) |->
      (ls_w <= SPEED_LINE_MAX) && (rs_w <= SPEED_LINE_MAX) &&
      ((ls_w == SPEED_LINE_MAX) || (rs_w == SPEED_LINE_MAX)))
    else $error("line word outside the speed envelope");

  // wall steering is symmetric around the straight speed
  a_wall_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == MODE_WALL) |->
      (16'(ls_w + rs_w) == 16'(SPEED_STRAIGHT + SPEED_STRAIGHT)))
    else $error("wall word speeds not symmetric");

endmodule

bind line_wall_follow_controller_core lwf_checker u_lwf_checker (.*);

`default_nettype wire
